### hw/rtl/hpd_pkg.sv
// shared types, constants and register codes of the heading pd turn controller
package hpd_pkg;

  localparam int AddrW = 5;

  // angle wrap bounds, hundredths of a degree
  localparam logic signed [17:0] AngleFull  = 18'sd36000;
  localparam logic signed [17:0] AngleHalf  = 18'sd18000;
  localparam logic signed [17:0] AngleHalf3 = 18'sd54000;

  // settle timer
  localparam logic [17:0] TickMs   = 18'd20;
  localparam logic [17:0] TimerMax = 18'd131071;

  // register reset values
  localparam logic [15:0] RstTarget = 16'd0;
  localparam logic [14:0] RstTol    = 15'd100;
  localparam logic [15:0] RstWait   = 16'd500;
  localparam logic [15:0] RstKp     = 16'd128;
  localparam logic [15:0] RstKd     = 16'd128;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_TOL    = 3'd1,
    REG_WAIT   = 3'd2,
    REG_KP     = 3'd3,
    REG_KD     = 3'd4
  } hpd_reg_t;

  typedef struct packed {
    logic [15:0] target_heading;
    logic [14:0] tolerance;
    logic [15:0] settle_wait_ms;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
  } hpd_cfg_t;

  typedef struct packed {
    logic signed [15:0] err;
    logic signed [16:0] diff;
    logic               settle;
  } hpd_err_t;

  typedef struct packed {
    logic ld_err;
    logic ld_prod;
    logic ld_out;
  } hpd_adv_t;

endpackage

### hw/rtl/hpd_if.sv
// valid/ready channel interfaces for input and result words
interface hpd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] heading;
  logic        start_req;
  modport source (output valid, heading, start_req, input ready);
  modport sink (input valid, heading, start_req, output ready);
endinterface

interface hpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive_power;
  logic               settled;
  modport source (output valid, drive_power, settled, input ready);
  modport sink (input valid, drive_power, settled, output ready);
endinterface

### hw/rtl/hpd_cfg.sv
// apb register file holding target, tolerance, wait time and gains
module hpd_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hpd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output hpd_pkg::hpd_cfg_t         cfg
);
  import hpd_pkg::*;

  hpd_cfg_t cfg_r, cfg_nxt;
  hpd_reg_t sel;
  logic     wr;

  assign sel    = hpd_reg_t'(paddr[AddrW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (sel)
        REG_TARGET: cfg_nxt.target_heading = pwdata[15:0];
        REG_TOL:    cfg_nxt.tolerance      = pwdata[14:0];
        REG_WAIT:   cfg_nxt.settle_wait_ms = pwdata[15:0];
        REG_KP:     cfg_nxt.prop_gain      = pwdata[15:0];
        REG_KD:     cfg_nxt.deriv_gain     = pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_TARGET: prdata = 32'(cfg_r.target_heading);
      REG_TOL:    prdata = 32'(cfg_r.tolerance);
      REG_WAIT:   prdata = 32'(cfg_r.settle_wait_ms);
      REG_KP:     prdata = 32'(cfg_r.prop_gain);
      REG_KD:     prdata = 32'(cfg_r.deriv_gain);
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_heading <= RstTarget;
      cfg_r.tolerance      <= RstTol;
      cfg_r.settle_wait_ms <= RstWait;
      cfg_r.prop_gain      <= RstKp;
      cfg_r.deriv_gain     <= RstKd;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hw/rtl/hpd_err.sv
// angle wrap, error difference and settle state update
module hpd_err (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ld,
  input  logic [15:0]       heading,
  input  logic              start_req,
  input  hpd_pkg::hpd_cfg_t cfg,
  output hpd_pkg::hpd_err_t stg
);
  import hpd_pkg::*;

  logic signed [15:0] prev_err_r, prev_err_nxt;
  logic [16:0]        timer_r, timer_nxt;
  logic               done_r, done_nxt;
  hpd_err_t           stg_r, stg_nxt;

  logic signed [17:0] d, wrapped;
  logic signed [15:0] err, prev_eff, neg_err;
  logic [16:0]        timer_eff, timer_upd;
  logic [17:0]        timer_sum;
  logic [14:0]        mag;
  logic               done_eff, in_tol, done_new;

  assign stg = stg_r;

  always_comb begin
    d = $signed({2'b00, cfg.target_heading}) - $signed({2'b00, heading});
    // bring the difference into -18000..17999
    if (d >= AngleHalf3)       wrapped = d - AngleFull - AngleFull;
    else if (d >= AngleHalf)   wrapped = d - AngleFull;
    else if (d >= -AngleHalf)  wrapped = d;
    else if (d >= -AngleHalf3) wrapped = d + AngleFull;
    else                       wrapped = d + AngleFull + AngleFull;
    err = wrapped[15:0];

    // start request clears state before this word
    prev_eff  = start_req ? 16'sd0 : prev_err_r;
    timer_eff = start_req ? 17'd0 : timer_r;
    done_eff  = start_req ? 1'b0 : done_r;

    neg_err = -err;
    mag     = err[15] ? neg_err[14:0] : err[14:0];
    in_tol  = mag < cfg.tolerance;

    timer_sum = {1'b0, timer_eff} + TickMs;
    if (!in_tol)                   timer_upd = timer_eff;
    else if (timer_sum > TimerMax) timer_upd = TimerMax[16:0];
    else                           timer_upd = timer_sum[16:0];
    done_new = timer_upd > {1'b0, cfg.settle_wait_ms};

    stg_nxt.err  = err;
    stg_nxt.diff = $signed({err[15], err}) - $signed({prev_eff[15], prev_eff});
    if (done_eff) begin
      prev_err_nxt   = prev_eff;
      timer_nxt      = timer_eff;
      done_nxt       = 1'b1;
      stg_nxt.settle = 1'b1;
    end else begin
      prev_err_nxt   = err;
      timer_nxt      = timer_upd;
      done_nxt       = done_new;
      stg_nxt.settle = done_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      timer_r    <= '0;
      done_r     <= 1'b0;
    end else if (ld) begin
      prev_err_r <= prev_err_nxt;
      timer_r    <= timer_nxt;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      stg_r <= stg_nxt;
    end
  end

endmodule

### hw/rtl/hpd_mac.sv
// gain products, sum, floor shift, saturation and result register
module hpd_mac (
  input  logic               clk,
  input  hpd_pkg::hpd_adv_t  adv,
  input  hpd_pkg::hpd_cfg_t  cfg,
  input  hpd_pkg::hpd_err_t  stg,
  output logic signed [15:0] drive_power,
  output logic               settled
);
  import hpd_pkg::*;

  logic signed [16:0] kp_s, kd_s;
  logic signed [32:0] prod_p_r, prod_p_nxt;
  logic signed [33:0] prod_d_r, prod_d_nxt;
  logic               settle_r;
  logic signed [34:0] sum;
  logic signed [26:0] sh;
  logic signed [15:0] sat;
  logic signed [15:0] power_r, power_nxt;
  logic               settled_r;

  assign kp_s       = $signed({1'b0, cfg.prop_gain});
  assign kd_s       = $signed({1'b0, cfg.deriv_gain});
  assign prod_p_nxt = kp_s * stg.err;
  assign prod_d_nxt = kd_s * stg.diff;

  always_comb begin
    sum = 35'(prod_p_r) + 35'(prod_d_r);
    sh  = sum[34:8];
    // saturate when the upper bits are not a pure sign extension
    if (!sh[26] && (sh[25:15] != '0))      sat = 16'sh7fff;
    else if (sh[26] && (sh[25:15] != '1))  sat = 16'sh8000;
    else                                   sat = sh[15:0];
    power_nxt = settle_r ? 16'sd0 : sat;
  end

  always_ff @(posedge clk) begin
    if (adv.ld_prod) begin
      prod_p_r <= prod_p_nxt;
      prod_d_r <= prod_d_nxt;
      settle_r <= stg.settle;
    end
    if (adv.ld_out) begin
      power_r   <= power_nxt;
      settled_r <= settle_r;
    end
  end

  assign drive_power = power_r;
  assign settled     = settled_r;

endmodule

### hw/rtl/heading_pd_turn_controller.sv
// top level: heading pd turn controller with four-stage word pipeline
// a word passes the input, error, product and result registers in turn before it is on out_word
// throughput: one word per cycle, every stage advances whenever the one after it has room
// settle state is updated as a word leaves the input register, so consecutive words chain
// reset: synchronous active-low rst_n empties the pipeline, clears error and timer state
// and loads the registers with their default target, tolerance, wait and gains
module heading_pd_turn_controller (
  input  logic                      clk,
  input  logic                      rst_n,
  hpd_in_if.sink                    in_word,
  hpd_out_if.source                 out_word,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hpd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import hpd_pkg::*;

  // stage valids: input reg, error reg, product reg, result reg
  logic        v1_r, v2_r, v3_r, v4_r;
  logic        v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic        rdy1, rdy2, rdy3, rdy4;
  logic        acc;
  logic [15:0] heading_r;
  logic        start_r;
  hpd_cfg_t    cfg;
  hpd_err_t    stg;
  hpd_adv_t    adv;

  // a stage has room when it is empty or its word moves on this cycle
  assign rdy4 = !v4_r || out_word.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_word.ready = rdy1;
  assign acc           = in_word.valid && rdy1;

  // load strobes for each downstream register
  assign adv.ld_err  = v1_r && rdy2;
  assign adv.ld_prod = v2_r && rdy3;
  assign adv.ld_out  = v3_r && rdy4;

  always_comb begin
    v1_nxt = acc || (v1_r && !rdy2);
    v2_nxt = adv.ld_err || (v2_r && !rdy3);
    v3_nxt = adv.ld_prod || (v3_r && !rdy4);
    v4_nxt = adv.ld_out || (v4_r && !out_word.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // input register, payload only
  always_ff @(posedge clk) begin
    if (acc) begin
      heading_r <= in_word.heading;
      start_r   <= in_word.start_req;
    end
  end

  // configuration registers
  hpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // wrapped error, derivative term and settle tracking
  hpd_err u_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (adv.ld_err),
    .heading   (heading_r),
    .start_req (start_r),
    .cfg       (cfg),
    .stg       (stg)
  );

  // pd products and saturated drive power
  hpd_mac u_mac (
    .clk         (clk),
    .adv         (adv),
    .cfg         (cfg),
    .stg         (stg),
    .drive_power (out_word.drive_power),
    .settled     (out_word.settled)
  );

  assign out_word.valid = v4_r;

endmodule
